[rtl/core/acpu_pkg.sv]
// Shared types and constants for the 8-bit accumulator machine.
package acpu_pkg;

  localparam int unsigned DATA_W    = 8;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned CFG_IDX_W = 1;

  // instruction opcodes
  localparam logic [DATA_W-1:0] OPC_STA = 8'd16;
  localparam logic [DATA_W-1:0] OPC_LDA = 8'd32;
  localparam logic [DATA_W-1:0] OPC_ADD = 8'd48;
  localparam logic [DATA_W-1:0] OPC_OR  = 8'd64;
  localparam logic [DATA_W-1:0] OPC_AND = 8'd80;
  localparam logic [DATA_W-1:0] OPC_NOT = 8'd96;
  localparam logic [DATA_W-1:0] OPC_JMP = 8'd128;
  localparam logic [DATA_W-1:0] OPC_JN  = 8'd144;
  localparam logic [DATA_W-1:0] OPC_JZ  = 8'd160;
  localparam logic [DATA_W-1:0] OPC_OUT = 8'd172;
  localparam logic [DATA_W-1:0] OPC_HLZ = 8'd240;

  // item operation codes
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
  localparam logic [OP_W-1:0] OP_STEP    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_ACC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_PC  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,   // zero the memory after reset
    ST_IDLE,
    ST_SIMPLE,  // write, restart, halted step, unused op
    ST_OPC,     // read opcode
    ST_ARG,     // opcode back, read operand
    ST_OPND,    // operand back, execute or read data
    ST_DATA     // data back, execute
  } eng_state_t;

endpackage

[rtl/core/acpu_ram.sv]
// Generic single-clock RAM, one write port and one registered read port.
module acpu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/accumulator_cpu_8bit.sv]
// Top level of the 8-bit accumulator machine: sequencer around one byte memory.
//
//   channel | direction | handshake            | word
//   in_     | in        | in_valid / in_stall  | in_op, in_address, in_data
//   out_    | out       | out_valid / out_stall| out_out_valid .. out_halted
//   cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Write, restart, halted-step and unused-op words pass through ST_SIMPLE alone. A step
// runs opcode read, operand read and execute, plus a data read before execute for
// LDA/ADD/OR/AND, which need a third read of the single memory read port.
// After reset a clearing pass zeroes every memory word; in_stall
// stays high meanwhile, cfg writes are taken at any time.
// The next word is accepted in the cycle the current one retires into the
// output register; a stalled output register holds the engine in its last step.
module accumulator_cpu_8bit #(
  parameter int unsigned MEM_DEPTH = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [acpu_pkg::OP_W-1:0]       in_op,
  input  logic [acpu_pkg::DATA_W-1:0]     in_address,
  input  logic [acpu_pkg::DATA_W-1:0]     in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_out_valid,
  output logic [acpu_pkg::DATA_W-1:0]     out_out_char,
  output logic [acpu_pkg::DATA_W-1:0]     out_accumulator,
  output logic [acpu_pkg::DATA_W-1:0]     out_program_count,
  output logic                            out_negative,
  output logic                            out_zero,
  output logic                            out_halted,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [acpu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [acpu_pkg::DATA_W-1:0]     cfg_data
);

  import acpu_pkg::*;

  localparam int unsigned AW = $clog2(MEM_DEPTH);
  localparam int unsigned NUM_BYTES = 1 << DATA_W;

  // byte address -> memory index, address taken modulo MEM_DEPTH
  typedef logic [AW-1:0] addr_tab_t [NUM_BYTES];

  function automatic addr_tab_t build_addr_tab();
    addr_tab_t t;
    for (int i = 0; i < NUM_BYTES; i++) begin
      t[i] = AW'(i % MEM_DEPTH);
    end
    return t;
  endfunction

  localparam addr_tab_t ADDR_TAB = build_addr_tab();

  eng_state_t        state_r, state_nxt;
  logic [OP_W-1:0]   item_op_r;
  logic [DATA_W-1:0] item_addr_r, item_data_r;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [DATA_W-1:0] pc_r, pc_nxt;
  logic              halt_r, halt_nxt;
  logic [DATA_W-1:0] init_acc_r, init_pc_r;
  logic [DATA_W-1:0] opc_r, opc_nxt;
  logic [DATA_W-1:0] arg_r, arg_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;

  logic              out_valid_r;
  logic              out_emit_r;
  logic [DATA_W-1:0] out_char_r, out_acc_r, out_pc_r;
  logic              out_halt_r;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  logic              finish, emit, slot_free, in_accept;
  logic [DATA_W-1:0] pc_p1, pc_p2;

  acpu_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign pc_p1     = pc_r + 8'd1;
  assign pc_p2     = pc_r + 8'd2;
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == ST_IDLE) || finish);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt   = state_r;
    acc_nxt     = acc_r;
    pc_nxt      = pc_r;
    halt_nxt    = halt_r;
    opc_nxt     = opc_r;
    arg_nxt     = arg_r;
    clr_cnt_nxt = clr_cnt_r;
    finish      = 1'b0;
    emit        = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = ADDR_TAB[item_addr_r];
    ram_wdata   = item_data_r;
    ram_raddr   = ADDR_TAB[pc_r];

    case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(MEM_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
      end
      ST_SIMPLE: begin
        if (slot_free) begin
          finish = 1'b1;
          case (item_op_r)
            OP_WRITE: begin
              ram_we = 1'b1;
            end
            OP_RESTART: begin
              acc_nxt  = init_acc_r;
              pc_nxt   = init_pc_r;
              halt_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_OPC: begin
        state_nxt = ST_ARG;
      end
      ST_ARG: begin
        opc_nxt   = ram_rdata;
        ram_raddr = ADDR_TAB[pc_p1];
        state_nxt = ST_OPND;
      end
      ST_OPND: begin
        // keep re-reading the operand so it survives an output stall
        ram_raddr = ADDR_TAB[pc_p1];
        case (opc_r)
          OPC_LDA, OPC_ADD, OPC_OR, OPC_AND: begin
            arg_nxt   = ram_rdata;
            ram_raddr = ADDR_TAB[ram_rdata];
            state_nxt = ST_DATA;
          end
          default: begin
            if (slot_free) begin
              finish = 1'b1;
              case (opc_r)
                OPC_STA: begin
                  ram_we    = 1'b1;
                  ram_waddr = ADDR_TAB[ram_rdata];
                  ram_wdata = acc_r;
                  pc_nxt    = pc_p2;
                end
                OPC_NOT: begin
                  acc_nxt = ~acc_r;
                  pc_nxt  = pc_p1;
                end
                OPC_JMP: pc_nxt = ram_rdata;
                OPC_JN:  pc_nxt = acc_r[DATA_W-1] ? ram_rdata : pc_p2;
                OPC_JZ:  pc_nxt = (acc_r == '0) ? ram_rdata : pc_p2;
                OPC_OUT: begin
                  emit   = 1'b1;
                  pc_nxt = pc_p1;
                end
                OPC_HLZ: begin
                  halt_nxt = 1'b1;
                  pc_nxt   = pc_p1;
                end
                default: pc_nxt = pc_p1;
              endcase
            end
          end
        endcase
      end
      ST_DATA: begin
        ram_raddr = ADDR_TAB[arg_r];
        if (slot_free) begin
          finish = 1'b1;
          pc_nxt = pc_p2;
          case (opc_r)
            OPC_LDA: acc_nxt = ram_rdata;
            OPC_ADD: acc_nxt = acc_r + ram_rdata;
            OPC_OR:  acc_nxt = acc_r | ram_rdata;
            OPC_AND: acc_nxt = acc_r & ram_rdata;
            default: begin
            end
          endcase
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (finish) begin
      state_nxt = ST_IDLE;
    end
    // halt as left by the word retiring now decides how a new step runs
    if (in_accept) begin
      state_nxt = (in_op == OP_STEP && !halt_nxt) ? ST_OPC : ST_SIMPLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      acc_r       <= '0;
      pc_r        <= '0;
      halt_r      <= 1'b0;
      init_acc_r  <= '0;
      init_pc_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      acc_r     <= acc_nxt;
      pc_r      <= pc_nxt;
      halt_r    <= halt_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_INIT_ACC: init_acc_r <= cfg_data;
          CFG_INIT_PC:  init_pc_r  <= cfg_data;
          default: begin
          end
        endcase
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    opc_r <= opc_nxt;
    arg_r <= arg_nxt;
    if (in_accept) begin
      item_op_r   <= in_op;
      item_addr_r <= in_address;
      item_data_r <= in_data;
    end
    if (finish) begin
      out_emit_r <= emit;
      out_char_r <= emit ? acc_r : '0;
      out_acc_r  <= acc_nxt;
      out_pc_r   <= pc_nxt;
      out_halt_r <= halt_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_out_valid     = out_emit_r;
  assign out_out_char      = out_char_r;
  assign out_accumulator   = out_acc_r;
  assign out_program_count = out_pc_r;
  assign out_negative      = out_acc_r[DATA_W-1];
  assign out_zero          = (out_acc_r == '0);
  assign out_halted        = out_halt_r;

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> in_stall)
    else $error("word accepted during memory clear");

  a_write_only_at_retire: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r != ST_CLEAR) |-> finish)
    else $error("memory written outside the retiring step");

  a_pc_holds_mid_word: assert property (@(posedge clk) disable iff (!rst_n)
    !finish |=> $stable(pc_r))
    else $error("program counter moved before the word retired");

  a_retire_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    finish |-> (!out_valid_r || !out_stall))
    else $error("output register overwritten while stalled");

  a_char_zero_without_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_emit_r) |-> (out_char_r == '0))
    else $error("character byte nonzero without OUT");

endmodule
